// ----- sv/rpbu_pkg.sv -----
// Shared types and constants for the RGB pixel blend unit.
`timescale 1ns / 1ps
`default_nettype none

package rpbu_pkg;

    localparam int unsigned CHAN_W   = 8;
    localparam int unsigned NUM_CH   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DAT_W = 8;

    localparam logic [CHAN_W-1:0] CHAN_MAX = 8'd255;

    // broadcast channel selector codes
    localparam logic [1:0] CH_BLUE  = 2'd0;
    localparam logic [1:0] CH_GREEN = 2'd1;
    localparam logic [1:0] CH_RED   = 2'd2;

    typedef enum logic [2:0] {
        MODE_MULTIPLY  = 3'd0,
        MODE_SUBTRACT  = 3'd1,
        MODE_SCREEN    = 3'd2,
        MODE_OVERLAY   = 3'd3,
        MODE_ADD       = 3'd4,
        MODE_SCALE     = 3'd5,
        MODE_BROADCAST = 3'd6
    } t_mode;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE         = 3'd0,
        REG_OFFSET       = 3'd1,
        REG_GAIN         = 3'd2,
        REG_CHANNEL_MASK = 3'd3,
        REG_CLEAR_MASK   = 3'd4,
        REG_BCAST_CH     = 3'd5
    } t_reg_idx;

    typedef struct packed {
        logic [CHAN_W-1:0] src_blue;
        logic [CHAN_W-1:0] src_green;
        logic [CHAN_W-1:0] src_red;
        logic [CHAN_W-1:0] base_blue;
        logic [CHAN_W-1:0] base_green;
        logic [CHAN_W-1:0] base_red;
    } t_in_word;

    typedef struct packed {
        logic [CHAN_W-1:0] out_blue;
        logic [CHAN_W-1:0] out_green;
        logic [CHAN_W-1:0] out_red;
    } t_out_word;

    // one pixel as channel array, index 0 blue, 1 green, 2 red
    typedef logic [NUM_CH-1:0][CHAN_W-1:0] t_pix;

    typedef struct packed {
        logic en_s1;
        logic en_s2;
    } t_lane_ctl;

endpackage

`default_nettype wire

// ----- sv/rpbu_lane.sv -----
// One channel lane: shared 8x8 multiplier stage, then rounding and mode select stage.
`timescale 1ns / 1ps
`default_nettype none

module rpbu_lane
    import rpbu_pkg::*;
(
    input  wire logic              i_clk,
    input  wire t_lane_ctl         i_ctl,
    input  wire t_mode             i_mode,
    input  wire logic [CHAN_W-1:0] i_offset,
    input  wire logic [CHAN_W-1:0] i_gain,
    input  wire logic              i_masked,
    input  wire logic [CHAN_W-1:0] i_src,
    input  wire logic [CHAN_W-1:0] i_base,
    output logic      [CHAN_W-1:0] o_res,
    output logic      [CHAN_W-1:0] o_src
);

    // round(n/255) for n <= 65025, as floor((n+127)/255)
    function automatic logic [CHAN_W-1:0] f_div255r(input logic [15:0] n);
        logic [16:0] x;
        logic [24:0] prod;
        logic [7:0]  e;
        logic [16:0] e255;
        logic [16:0] rem;
        begin
            x    = {1'b0, n} + 17'd127;
            prod = {x, 8'b0} + {8'b0, x};
            e    = prod[23:16];
            e255 = {1'b0, e, 8'b0} - {9'b0, e};
            rem  = x - e255;
            f_div255r = (rem >= 17'd255) ? e + 8'd1 : e;
        end
    endfunction

    logic              inv;
    logic [CHAN_W-1:0] ma;
    logic [CHAN_W-1:0] mb;
    logic [15:0]       r_p;
    logic [CHAN_W-1:0] r_s;
    logic [CHAN_W-1:0] r_b;
    logic [16:0]       p2;
    logic [15:0]       n_div;
    logic [CHAN_W-1:0] q;
    logic [CHAN_W:0]   sum;
    logic [CHAN_W-1:0] n_res;
    logic [CHAN_W-1:0] r_res;
    logic [CHAN_W-1:0] r_src2;

    // stage 1: pick multiplier operands; 255-x is the bitwise complement
    always_comb begin
        inv = (i_mode == MODE_SCREEN) || ((i_mode == MODE_OVERLAY) && i_base[7]);
        ma  = inv ? ~i_src : i_src;
        if (i_mode == MODE_SCALE) begin
            mb = i_gain;
        end else begin
            mb = inv ? ~i_base : i_base;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s1) begin
            r_p <= {8'b0, ma} * {8'b0, mb};
            r_s <= i_src;
            r_b <= i_base;
        end
    end

    // stage 2: rounding divide and per-mode result
    always_comb begin
        p2 = {r_p, 1'b0};
        if (i_mode == MODE_OVERLAY) begin
            if (r_b[7]) begin
                n_div = 16'(17'd65025 - p2);
            end else begin
                n_div = p2[15:0];
            end
        end else begin
            n_div = r_p;
        end
        q   = f_div255r(n_div);
        sum = {1'b0, r_s} + {1'b0, i_offset};
        case (i_mode)
            MODE_MULTIPLY: n_res = q;
            MODE_SUBTRACT: n_res = (r_s >= r_b) ? r_s - r_b : '0;
            MODE_SCREEN:   n_res = ~q;
            MODE_OVERLAY:  n_res = q;
            MODE_ADD: begin
                if (!i_masked) begin
                    n_res = r_s;
                end else begin
                    n_res = sum[CHAN_W] ? CHAN_MAX : sum[CHAN_W-1:0];
                end
            end
            MODE_SCALE: begin
                if (!i_masked) begin
                    n_res = r_s;
                end else begin
                    n_res = (r_p > 16'(CHAN_MAX)) ? CHAN_MAX : r_p[CHAN_W-1:0];
                end
            end
            default:       n_res = r_s;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_s2) begin
            r_res  <= n_res;
            r_src2 <= r_s;
        end
    end

    assign o_res = r_res;
    assign o_src = r_src2;

endmodule

`default_nettype wire

// ----- sv/rpbu_merge.sv -----
// Merge stage: broadcast select and clear mask over the lanes, output register with skid word.
`timescale 1ns / 1ps
`default_nettype none

module rpbu_merge
    import rpbu_pkg::*;
(
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_mode              i_mode,
    input  wire logic [NUM_CH-1:0]  i_clear_mask,
    input  wire logic [1:0]         i_bcast_ch,
    input  wire logic               i_valid,
    input  wire t_pix               i_res,
    input  wire t_pix               i_src,
    output logic                    o_stall,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output t_out_word               o_data
);

    logic [1:0] sel;
    t_pix       pix;
    t_out_word  word;
    logic       out_take;
    logic       in_take;
    logic       r_out_v;
    logic       n_out_v;
    t_out_word  r_out;
    t_out_word  n_out;
    logic       r_skid_v;
    logic       n_skid_v;
    t_out_word  r_skid;
    t_out_word  n_skid;

    always_comb begin
        sel = (i_bcast_ch > CH_RED) ? CH_RED : i_bcast_ch;
        for (int c = 0; c < NUM_CH; c++) begin
            pix[c] = (i_mode == MODE_BROADCAST) ? i_src[sel] : i_res[c];
            if (i_clear_mask[c]) begin
                pix[c] = '0;
            end
        end
        word.out_blue  = pix[0];
        word.out_green = pix[1];
        word.out_red   = pix[2];
    end

    assign out_take = r_out_v && !i_stall;
    assign in_take  = i_valid && !r_skid_v;

    always_comb begin
        n_out_v  = r_out_v;
        n_out    = r_out;
        n_skid_v = r_skid_v;
        n_skid   = r_skid;
        if (r_skid_v) begin
            // drain the skid word once the output moves
            if (out_take) begin
                n_out    = r_skid;
                n_skid_v = 1'b0;
            end
        end else if (in_take) begin
            if (!r_out_v || out_take) begin
                n_out   = word;
                n_out_v = 1'b1;
            end else begin
                n_skid   = word;
                n_skid_v = 1'b1;
            end
        end else if (out_take) begin
            n_out_v = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            r_out_v  <= n_out_v;
            r_skid_v <= n_skid_v;
        end
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_stall = r_skid_v;
    assign o_valid = r_out_v;
    assign o_data  = r_out;

endmodule

`default_nettype wire

// ----- sv/rgb_pixel_blend_unit_core.sv -----
// Top level of the RGB pixel blend unit: config registers, three channel lanes, merge stage.
// An accepted input word is registered in lane stage one, lane stage two and the merge output register.
// Throughput: one pixel per cycle while the output is not stalled; the lanes run a 2-stage pipe and the
// merge stage holds an output register plus one skid word, so input stall comes from a register only.
// Reset (synchronous, active low) empties the pipe and sets the config registers to their
// reset values; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module rgb_pixel_blend_unit_core
    import rpbu_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    input  wire logic                 i_valid,
    output logic                      o_stall,
    input  wire t_in_word             i_data,
    output logic                      o_valid,
    input  wire logic                 i_stall,
    output t_out_word                 o_data
);

    t_mode              r_mode;
    logic [CHAN_W-1:0]  r_offset;
    logic [CHAN_W-1:0]  r_gain;
    logic [NUM_CH-1:0]  r_channel_mask;
    logic [NUM_CH-1:0]  r_clear_mask;
    logic [1:0]         r_bcast_ch;

    logic       r_v1;
    logic       n_v1;
    logic       r_v2;
    logic       n_v2;
    logic       rdy1;
    logic       rdy2;
    logic       m_stall;
    t_lane_ctl  lane_ctl;
    t_pix       src;
    t_pix       base;
    t_pix       lane_res;
    t_pix       lane_src;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= MODE_MULTIPLY;
            r_offset       <= '0;
            r_gain         <= 8'd1;
            r_channel_mask <= 3'b111;
            r_clear_mask   <= '0;
            r_bcast_ch     <= CH_BLUE;
        end else if (i_cfg_we) begin
            case (t_reg_idx'(i_cfg_idx))
                REG_MODE:         r_mode         <= t_mode'(i_cfg_data[2:0]);
                REG_OFFSET:       r_offset       <= i_cfg_data;
                REG_GAIN:         r_gain         <= i_cfg_data;
                REG_CHANNEL_MASK: r_channel_mask <= i_cfg_data[NUM_CH-1:0];
                REG_CLEAR_MASK:   r_clear_mask   <= i_cfg_data[NUM_CH-1:0];
                REG_BCAST_CH:     r_bcast_ch     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // bubble-collapsing pipe control; a stage loads when it is empty or moves on
    always_comb begin
        rdy2           = !r_v2 || !m_stall;
        rdy1           = !r_v1 || rdy2;
        n_v1           = rdy1 ? i_valid : r_v1;
        n_v2           = rdy2 ? r_v1 : r_v2;
        lane_ctl.en_s1 = rdy1;
        lane_ctl.en_s2 = rdy2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
        end
    end

    assign o_stall = !rdy1;

    assign src[0]  = i_data.src_blue;
    assign src[1]  = i_data.src_green;
    assign src[2]  = i_data.src_red;
    assign base[0] = i_data.base_blue;
    assign base[1] = i_data.base_green;
    assign base[2] = i_data.base_red;

    for (genvar c = 0; c < NUM_CH; c++) begin : g_lane
        rpbu_lane u_lane (
            .i_clk    (i_clk),
            .i_ctl    (lane_ctl),
            .i_mode   (r_mode),
            .i_offset (r_offset),
            .i_gain   (r_gain),
            .i_masked (r_channel_mask[c]),
            .i_src    (src[c]),
            .i_base   (base[c]),
            .o_res    (lane_res[c]),
            .o_src    (lane_src[c])
        );
    end

    rpbu_merge u_merge (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_mode       (r_mode),
        .i_clear_mask (r_clear_mask),
        .i_bcast_ch   (r_bcast_ch),
        .i_valid      (r_v2),
        .i_res        (lane_res),
        .i_src        (lane_src),
        .o_stall      (m_stall),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_data       (o_data)
    );

    // backpressure on the input only ever comes from a held output word
    a_stall_has_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("input stalled with no output word held");

    // an accepted word into an empty pipe reaches the output through stage one, stage two and the merge register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && !r_v1 && !r_v2 && !o_valid) |-> ##3 o_valid)
        else $error("output word missing three cycles after accept");

    // a full skid stalls stage two, which must then hold its word
    a_hold_stage2: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && m_stall) |=> r_v2)
        else $error("stage two dropped a word while merge was stalled");

endmodule

`default_nettype wire

// ----- verif/rgb_pixel_blend_unit_core_tb.sv -----
// Self-checking testbench for the RGB pixel blend unit: random stalls, all modes, config sweeps.
`timescale 1ns / 1ps

module rgb_pixel_blend_unit_core_tb;
    import rpbu_pkg::*;

    localparam int PIPE_LAT    = 3;
    localparam int NUM_PHASES  = 32;
    localparam int PHASE_ITEMS = 31;
    localparam int QUIET_LIMIT = 2000;

    // codes the package leaves unnamed
    localparam logic [2:0]           MODE_UNUSED = 3'd7;
    localparam logic [1:0]           CH_TOP      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_7 = 3'd7;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_DAT_W-1:0] i_cfg_data;
    logic                 i_valid;
    logic                 o_stall;
    t_in_word             i_data;
    logic                 o_valid;
    logic                 i_stall = 1'b0;
    t_out_word            o_data;

    bit steady;
    int quiet_cycles = 0;

    class pixel_blend_checker;
        logic [2:0] mode;
        logic [7:0] offset;
        logic [7:0] gain;
        logic [2:0] chan_mask;
        logic [2:0] clear_mask;
        logic [1:0] bcast_sel;
        t_out_word  expected_pixels[$];
        int         mismatches;

        function new();
            mode       = MODE_MULTIPLY;
            offset     = 8'd0;
            gain       = 8'd1;
            chan_mask  = 3'b111;
            clear_mask = 3'b000;
            bcast_sel  = CH_BLUE;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DAT_W-1:0] v);
            case (idx)
                REG_MODE:         mode       = v[2:0];
                REG_OFFSET:       offset     = v;
                REG_GAIN:         gain       = v;
                REG_CHANNEL_MASK: chan_mask  = v[2:0];
                REG_CLEAR_MASK:   clear_mask = v[2:0];
                REG_BCAST_CH:     bcast_sel  = v[1:0];
                default: ;
            endcase
        endfunction

        // round-half-up of n / 255
        function int div255(int n);
            return (2 * n + 255) / 510;
        endfunction

        function int blend_chan(int s, int b, bit sel);
            int off;
            int gn;
            int t;
            off = offset;
            gn  = gain;
            case (mode)
                MODE_MULTIPLY: t = div255(s * b);
                MODE_SUBTRACT: t = (s >= b) ? s - b : 0;
                MODE_SCREEN:   t = 255 - div255((255 - s) * (255 - b));
                MODE_OVERLAY:  t = (b < 128) ? div255(2 * s * b)
                                             : div255(65025 - 2 * (255 - s) * (255 - b));
                MODE_ADD:      t = sel ? s + off : s;
                MODE_SCALE:    t = sel ? s * gn : s;
                default:       t = s;
            endcase
            return (t > 255) ? 255 : t;
        endfunction

        function t_out_word blend_pixel(t_in_word w);
            int        s[3];
            int        b[3];
            int        r[3];
            int        pick;
            t_out_word o;
            s[0] = w.src_blue;
            s[1] = w.src_green;
            s[2] = w.src_red;
            b[0] = w.base_blue;
            b[1] = w.base_green;
            b[2] = w.base_red;
            // top selector code saturates to red
            pick = (bcast_sel > CH_RED) ? CH_RED : bcast_sel;
            for (int c = 0; c < 3; c++) begin
                if (mode == MODE_BROADCAST) begin
                    r[c] = s[pick];
                end else begin
                    r[c] = blend_chan(s[c], b[c], chan_mask[c]);
                end
                if (clear_mask[c]) begin
                    r[c] = 0;
                end
            end
            o.out_blue  = 8'(r[0]);
            o.out_green = 8'(r[1]);
            o.out_red   = 8'(r[2]);
            return o;
        endfunction

        function void note_pixel(t_in_word w);
            expected_pixels.insert(expected_pixels.size(), blend_pixel(w));
        endfunction

        function void check_pixel(t_out_word got);
            t_out_word exp_px;
            if (expected_pixels.size() == 0) begin
                if (mismatches < 10) begin
                    $display("mismatch: unexpected word b=%0d g=%0d r=%0d",
                             got.out_blue, got.out_green, got.out_red);
                end
                mismatches++;
            end else begin
                exp_px = expected_pixels.pop_front();
                if (got.out_blue !== exp_px.out_blue || got.out_green !== exp_px.out_green ||
                    got.out_red !== exp_px.out_red) begin
                    if (mismatches < 10) begin
                        $display("mismatch: expected b=%0d g=%0d r=%0d, got b=%0d g=%0d r=%0d",
                                 exp_px.out_blue, exp_px.out_green, exp_px.out_red,
                                 got.out_blue, got.out_green, got.out_red);
                    end
                    mismatches++;
                end
            end
        endfunction

        function int pending();
            return expected_pixels.size();
        endfunction
    endclass

    pixel_blend_checker board = new();

    rgb_pixel_blend_unit_core u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_data     (i_data),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        i_stall <= !steady && ($urandom_range(99) < 21);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            board.check_pixel(o_data);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles", QUIET_LIMIT);
            $display("rgb_pixel_blend_unit_core verification failed");
            $finish;
        end
    end

    function automatic logic [7:0] rand_chan();
        case ($urandom_range(7))
            0:       return 8'd0;
            1:       return 8'd255;
            2:       return 8'd127;
            3:       return 8'd128;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic t_in_word rand_pixel();
        t_in_word w;
        w.src_blue   = rand_chan();
        w.src_green  = rand_chan();
        w.src_red    = rand_chan();
        w.base_blue  = rand_chan();
        w.base_green = rand_chan();
        w.base_red   = rand_chan();
        return w;
    endfunction

    task automatic send_pixel(input t_in_word w);
        while (!steady && $urandom_range(99) < 21) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= w;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        board.note_pixel(w);
    endtask

    // hold the sender until every expected word is back and the pipe is empty
    task automatic drain_results();
        i_valid <= 1'b0;
        while (board.pending() != 0) @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] v);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= v;
        @(posedge i_clk);
        board.set_reg(idx, v);
    endtask

    t_in_word   corner_px [8];
    logic [2:0] mode_order [8];
    logic [1:0] bcast_order [4];
    logic [7:0] off_v;
    logic [7:0] gain_v;
    logic [2:0] cmask_v;
    logic [2:0] clr_v;
    int         grp;

    initial begin
        corner_px   = '{48'h000000_000000, 48'hFFFFFF_FFFFFF, 48'hFF0080_00FF7F,
                        48'h01FE7F_807F01, 48'h807FFF_80807F, 48'h00FFFF_FFFF00,
                        48'hFFFF00_000000, 48'h7F8001_FE017F};
        mode_order  = '{MODE_MULTIPLY, MODE_SUBTRACT, MODE_SCREEN, MODE_OVERLAY,
                        MODE_ADD, MODE_SCALE, MODE_BROADCAST, MODE_UNUSED};
        bcast_order = '{CH_TOP, CH_BLUE, CH_GREEN, CH_RED};
        steady       = 1'b0;
        i_rst_n    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        i_valid    <= 1'b0;
        i_data     <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // corners under reset settings, then add and scale with reset offset and gain, then overlay
        foreach (corner_px[k]) send_pixel(corner_px[k]);
        drain_results();
        write_reg(REG_MODE, {5'b0, MODE_ADD});
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 4; k++) send_pixel(corner_px[k + 2]);
        drain_results();
        write_reg(REG_MODE, {5'b0, MODE_SCALE});
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 4; k++) send_pixel(corner_px[k + 4]);
        drain_results();
        write_reg(REG_MODE, {5'b0, MODE_OVERLAY});
        i_cfg_we <= 1'b0;
        for (int k = 0; k < 4; k++) send_pixel(corner_px[k + 1]);

        for (int p = 0; p < NUM_PHASES; p++) begin
            grp = p / 8;
            drain_results();
            steady = (p >= 10 && p < 15);
            off_v   = (grp == 0) ? 8'd0 : (grp == 1) ? 8'd255 : 8'($urandom);
            gain_v  = (grp == 0) ? 8'd0 : (grp == 1) ? 8'd255 :
                      (grp == 2) ? 8'd1 : 8'($urandom);
            cmask_v = (grp == 0) ? 3'b111 : (grp == 1) ? 3'b000 : 3'($urandom);
            clr_v   = (p == 9) ? 3'b111 : (p % 5 == 4) ? 3'($urandom) : 3'b000;
            // upper data bits are random; the block keeps only the register width
            write_reg(REG_MODE, {5'($urandom), mode_order[p % 8]});
            write_reg(REG_OFFSET, off_v);
            write_reg(REG_GAIN, gain_v);
            write_reg(REG_CHANNEL_MASK, {5'($urandom), cmask_v});
            write_reg(REG_CLEAR_MASK, {5'($urandom), clr_v});
            write_reg(REG_BCAST_CH, {6'($urandom), bcast_order[grp]});
            if ($urandom_range(1) == 1) begin
                write_reg(($urandom_range(1) == 1) ? REG_SPARE_6 : REG_SPARE_7, 8'($urandom));
            end
            i_cfg_we <= 1'b0;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (p == 3 && k == 15) begin
                    drain_results();
                end
                send_pixel(rand_pixel());
            end
        end

        steady = 1'b0;
        drain_results();
        if (board.mismatches == 0 && board.pending() == 0) begin
            $display("rgb_pixel_blend_unit_core verification clean");
        end else begin
            $display("rgb_pixel_blend_unit_core verification failed");
        end
        $finish;
    end

endmodule
